// File: rtl/chacha_pkg.sv
// Shared types and constants for the ChaCha20 stream cipher block.
package chacha_pkg;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_INIT_CTR = 3'd6;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // load initial state, select counter source
        logic load_init;  // counter from initial_counter
        logic col;        // round step: 1 column, 0 diagonal
        logic round;      // run one round
        logic finish;     // add input words back, bump counter
    } t_dp_cmd;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // one quarter round on four words
    function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
        logic [31:0] a1, b1, c1, d1;
        a1 = a + b;   d1 = rotl(d ^ a1, 16);
        c1 = c + d1;  b1 = rotl(b ^ c1, 12);
        a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
        c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
        qr = {d1, c1, b1, a1};
    endfunction
endpackage

// File: rtl/chacha20_stream_cipher.sv
// Top level of the ChaCha20 byte stream cipher.
// Usage:
//   Configuration: write key, nonce and initial counter through i_cfg_we,
//   i_cfg_idx (register index 0..6) and i_cfg_data while the block is idle.
//   Input stream s_axis: tdata = data_in byte, tuser = start_of_message.
//   A start item restarts the keystream at initial_counter, byte zero.
//   Output stream m_axis: tdata = data_in XOR keystream byte, one per item.
// Timing:
//   For a byte that uses an already made keystream block, the result is
//   registered and shows in the cycle after acceptance.
//   The first byte of each 64-byte block or of a message waits for the
//   block function: round steps on four quarter-round units, a feed-forward
//   step and an output step. No new byte is taken while a block is made.
// Reset: clears the configuration to zero, the counter, byte position and
//   block-held flag; the stream starts at counter zero without a start item.
// Stall: the output register holds while m_axis_tready is low, and no new
//   item is taken until it can move on.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
    input  logic        s_axis_tuser,   // [0] start_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] data_out
);
    import chacha_pkg::*;

    t_dp_cmd    cmd;
    logic [5:0] pos;
    logic [7:0] ks_byte;
    logic       xor_load;
    logic [7:0] r_data, r_out;

    chacha_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_start(s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .o_pos(pos), .o_xor_load(xor_load)
    );

    chacha_dp u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd(cmd), .i_pos(pos), .o_ks_byte(ks_byte)
    );

    // hold input byte; form result
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_data <= s_axis_tdata;
        if (xor_load) begin
            r_out <= ((s_axis_tvalid && s_axis_tready) ? s_axis_tdata : r_data) ^ ks_byte;
        end
    end

    assign m_axis_tdata = r_out;
endmodule

// File: rtl/chacha_dp.sv
// Datapath: config registers, working state, four quarter-round units, keystream.
module chacha_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    input  chacha_pkg::t_dp_cmd i_cmd,
    input  logic [5:0]          i_pos,
    output logic [7:0]          o_ks_byte
);
    import chacha_pkg::*;

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nlo;
    logic [31:0] r_nhi, r_ictr, r_ctr;
    logic [31:0] r_w [16];
    logic [31:0] r_init [16];
    logic [31:0] r_ks [16];
    logic [31:0] n_w [16];
    logic [31:0] ctr_sel;
    logic [127:0] q0, q1, q2, q3;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_nlo <= '0; r_nhi <= '0; r_ictr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY0:     r_key0 <= i_cfg_data;
                REG_KEY1:     r_key1 <= i_cfg_data;
                REG_KEY2:     r_key2 <= i_cfg_data;
                REG_KEY3:     r_key3 <= i_cfg_data;
                REG_NONCE_LO: r_nlo  <= i_cfg_data;
                REG_NONCE_HI: r_nhi  <= i_cfg_data[31:0];
                REG_INIT_CTR: r_ictr <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign ctr_sel = i_cmd.load_init ? r_ictr : r_ctr;

    // quarter rounds, column or diagonal
    always_comb begin
        if (i_cmd.col) begin
            q0 = qr(r_w[0], r_w[4], r_w[8],  r_w[12]);
            q1 = qr(r_w[1], r_w[5], r_w[9],  r_w[13]);
            q2 = qr(r_w[2], r_w[6], r_w[10], r_w[14]);
            q3 = qr(r_w[3], r_w[7], r_w[11], r_w[15]);
        end else begin
            q0 = qr(r_w[0], r_w[5], r_w[10], r_w[15]);
            q1 = qr(r_w[1], r_w[6], r_w[11], r_w[12]);
            q2 = qr(r_w[2], r_w[7], r_w[8],  r_w[13]);
            q3 = qr(r_w[3], r_w[4], r_w[9],  r_w[14]);
        end
        for (int i = 0; i < 16; i++) n_w[i] = r_w[i];
        if (i_cmd.col) begin
            {n_w[12], n_w[8],  n_w[4], n_w[0]} = q0;
            {n_w[13], n_w[9],  n_w[5], n_w[1]} = q1;
            {n_w[14], n_w[10], n_w[6], n_w[2]} = q2;
            {n_w[15], n_w[11], n_w[7], n_w[3]} = q3;
        end else begin
            {n_w[15], n_w[10], n_w[5], n_w[0]} = q0;
            {n_w[12], n_w[11], n_w[6], n_w[1]} = q1;
            {n_w[13], n_w[8],  n_w[7], n_w[2]} = q2;
            {n_w[14], n_w[9],  n_w[4], n_w[3]} = q3;
        end
    end

    // block counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else if (i_cmd.load) begin
            r_ctr <= ctr_sel;
        end else if (i_cmd.finish) begin
            r_ctr <= r_ctr + 32'd1;
        end
    end

    // working state, input copy and keystream
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_init[0] <= SIGMA0; r_init[1] <= SIGMA1;
            r_init[2] <= SIGMA2; r_init[3] <= SIGMA3;
            r_init[4] <= r_key0[31:0]; r_init[5] <= r_key0[63:32];
            r_init[6] <= r_key1[31:0]; r_init[7] <= r_key1[63:32];
            r_init[8] <= r_key2[31:0]; r_init[9] <= r_key2[63:32];
            r_init[10] <= r_key3[31:0]; r_init[11] <= r_key3[63:32];
            r_init[12] <= ctr_sel;
            r_init[13] <= r_nlo[31:0]; r_init[14] <= r_nlo[63:32];
            r_init[15] <= r_nhi;
            r_w[0] <= SIGMA0; r_w[1] <= SIGMA1;
            r_w[2] <= SIGMA2; r_w[3] <= SIGMA3;
            r_w[4] <= r_key0[31:0]; r_w[5] <= r_key0[63:32];
            r_w[6] <= r_key1[31:0]; r_w[7] <= r_key1[63:32];
            r_w[8] <= r_key2[31:0]; r_w[9] <= r_key2[63:32];
            r_w[10] <= r_key3[31:0]; r_w[11] <= r_key3[63:32];
            r_w[12] <= ctr_sel;
            r_w[13] <= r_nlo[31:0]; r_w[14] <= r_nlo[63:32];
            r_w[15] <= r_nhi;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 16; i++) r_w[i] <= n_w[i];
        end
        if (i_cmd.finish) begin
            for (int i = 0; i < 16; i++) r_ks[i] <= r_w[i] + r_init[i];
        end
    end

    // pick keystream byte
    logic [31:0] ks_word;
    assign ks_word   = r_ks[i_pos[5:2]];
    assign o_ks_byte = 8'(ks_word >> {i_pos[1:0], 3'b000});
endmodule

// File: rtl/chacha_ctrl.sv
// Controller: handshake, byte position, round sequencing.
module chacha_ctrl #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_start,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output chacha_pkg::t_dp_cmd o_cmd,
    output logic [5:0]          o_pos,
    output logic                o_xor_load
);
    import chacha_pkg::*;

    localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FIN, S_OUT} t_state;

    t_state      r_state;
    logic [RW-1:0] r_rcnt;
    logic [5:0]  r_pos;
    logic        r_ready;
    logic        r_ovalid;
    logic        acc;
    logic        out_free;

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign acc        = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_pos      = r_pos;

    // commands
    always_comb begin
        o_cmd = '0;
        o_xor_load = 1'b0;
        o_cmd.col = !r_rcnt[0];
        if (acc && (i_in_start || !r_ready)) begin
            o_cmd.load = 1'b1;
            o_cmd.load_init = i_in_start;
        end
        if (r_state == S_ROUND) o_cmd.round = 1'b1;
        if (r_state == S_FIN) o_cmd.finish = 1'b1;
        if ((acc && !(i_in_start || !r_ready)) || (r_state == S_OUT && out_free))
            o_xor_load = 1'b1;
    end

    // state and registered flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rcnt   <= '0;
            r_pos    <= '0;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // set on a new result, drop once taken
            r_ovalid <= o_xor_load || (r_ovalid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_in_start || !r_ready) begin
                            if (i_in_start) r_pos <= '0;
                            r_rcnt  <= '0;
                            r_state <= S_ROUND;
                        end else begin
                            r_pos    <= r_pos + 6'd1;
                            if (r_pos == 6'd63) r_ready <= 1'b0;
                        end
                    end
                end
                S_ROUND: begin
                    r_rcnt <= r_rcnt + RW'(1);
                    if (r_rcnt == RW'(2 * DOUBLE_ROUNDS - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_ready <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_pos    <= r_pos + 6'd1;
                        if (r_pos == 6'd63) r_ready <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: dv/chacha20_stream_cipher_test.sv
// Self-checking testbench for the ChaCha20 byte stream cipher.
module chacha20_stream_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;
    import chacha_pkg::*;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int DRAIN_CYCLES = 60;

    // keystream predictor and queue of expected cipher bytes
    class cipher_scoreboard;
        logic [63:0] key_reg [4];
        logic [63:0] nonce_lo;
        logic [31:0] nonce_hi;
        logic [31:0] ctr_init;
        logic [31:0] ks_words [16];
        logic [31:0] blk_ctr;
        logic [5:0]  byte_pos;
        bit          blk_held;
        logic [7:0]  expected_bytes [$];
        int          errors;

        function new();
            for (int i = 0; i < 4; i++) key_reg[i] = '0;
            nonce_lo = '0;
            nonce_hi = '0;
            ctr_init = '0;
            blk_ctr = '0;
            byte_pos = '0;
            blk_held = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_KEY0: key_reg[0] = val;
                REG_KEY1: key_reg[1] = val;
                REG_KEY2: key_reg[2] = val;
                REG_KEY3: key_reg[3] = val;
                REG_NONCE_LO: nonce_lo = val;
                REG_NONCE_HI: nonce_hi = val[31:0];
                REG_INIT_CTR: ctr_init = val[31:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] rol32(logic [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void quarter(ref logic [31:0] w [16], input int a, int b, int c, int d);
            w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
            w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
            w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
            w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
        endfunction

        function void build_block();
            logic [31:0] init [16];
            logic [31:0] work [16];
            init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
            for (int i = 0; i < 4; i++) begin
                init[4 + 2 * i] = key_reg[i][31:0];
                init[5 + 2 * i] = key_reg[i][63:32];
            end
            init[12] = blk_ctr;
            init[13] = nonce_lo[31:0];
            init[14] = nonce_lo[63:32];
            init[15] = nonce_hi;
            work = init;
            for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
                quarter(work, 0, 4, 8, 12);
                quarter(work, 1, 5, 9, 13);
                quarter(work, 2, 6, 10, 14);
                quarter(work, 3, 7, 11, 15);
                quarter(work, 0, 5, 10, 15);
                quarter(work, 1, 6, 11, 12);
                quarter(work, 2, 7, 8, 13);
                quarter(work, 3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) ks_words[i] = work[i] + init[i];
        endfunction

        // note an accepted input item and predict its output byte
        function void note_input(logic [7:0] din, logic som);
            logic [31:0] word;
            if (som) begin
                blk_ctr = ctr_init;
                byte_pos = '0;
                blk_held = 0;
            end
            if (!blk_held) begin
                build_block();
                blk_ctr = blk_ctr + 32'd1;
                blk_held = 1;
            end
            word = ks_words[byte_pos[5:2]];
            expected_bytes.push_back(din ^ word[8 * byte_pos[1:0] +: 8]);
            byte_pos = byte_pos + 6'd1;
            if (byte_pos == 0) blk_held = 0;
        endfunction

        // compare an accepted output item with the oldest expectation
        function void check_output(logic [7:0] dout);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output item, actual %02h", $realtime, dout);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (dout !== want) begin
                $display("%0t: data_out mismatch, expected %02h actual %02h",
                         $realtime, want, dout);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_in
    logic        s_axis_tuser = 0;    // [0] start_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;        // [7:0] data_out

    cipher_scoreboard sb = new();
    bit hold_sink = 0;
    bit idle_out = 1;

    chacha20_stream_cipher #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // sample outputs at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 0;
                repeat (300) @(negedge i_clk);
                hold_sink = 0;
            end
            gap = idle_out ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1;
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // send one item; wait for acceptance, then a random gap unless no_gap is set
    task automatic send_byte(logic [7:0] din, logic som, bit no_gap = 0);
        int gap;
        s_axis_tvalid <= 1;
        s_axis_tdata <= din;
        s_axis_tuser <= som;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(din, som);
        @(negedge i_clk);
        gap = (no_gap || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 0;
        while (sb.expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_setting(logic [63:0] fill, logic [31:0] ctr);
        for (int i = 0; i < 4; i++)
            write_cfg(3'(REG_KEY0 + i), fill == 0 ? 64'd0 : fill == '1 ? '1 :
                      {$urandom, $urandom});
        write_cfg(REG_NONCE_LO, fill == 0 ? 64'd0 : fill == '1 ? '1 : {$urandom, $urandom});
        write_cfg(REG_NONCE_HI, fill == 0 ? 64'd0 : fill == '1 ? '1 : {32'd0, $urandom});
        write_cfg(REG_INIT_CTR, {32'd0, ctr});
    endtask

    initial begin
        int len;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: stream with no start after reset, zero registers
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hA5, 0);
        wait_idle();

        // directed: all-ones registers, counter wrap across a block boundary
        load_setting('1, 32'hFFFF_FFFF);
        send_byte(8'h5A, 1);
        for (int i = 0; i < 70; i++) send_byte(8'(i * 37), 0, 1);
        // start in mid-block
        send_byte(8'hFF, 1);
        send_byte(8'h00, 0);
        wait_idle();

        // random phases with random settings, the last one with zero settings
        idle_out = 0;
        for (int ph = 0; ph < 6; ph++) begin
            load_setting(ph == 5 ? 64'd0 : 64'd1, ph == 5 ? 32'd0 : $urandom);
            if (ph == 2) hold_sink = 1;
            for (int m = 0; m < 3; m++) begin
                len = $urandom_range(1, 100);
                send_byte(8'($urandom), 1, ph == 2);
                for (int i = 1; i < len; i++)
                    send_byte(8'($urandom), $urandom_range(0, 40) == 0, ph == 2);
            end
            if (ph == 3) idle_out = 1;
            if (ph == 4) idle_out = 0;
            wait_idle();
        end

        if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/chacha_pkg.sv
rtl/chacha_dp.sv
rtl/chacha_ctrl.sv
rtl/chacha20_stream_cipher.sv
dv/chacha20_stream_cipher_test.sv
